// File: hdl/lpfb_pkg.sv
// shared types, codes and helpers for the lcd pixel frame buffer engine
`timescale 1ns / 1ps

package lpfb_pkg;

  // widest store index: 128 columns by 16 pages
  localparam int unsigned AddrMaxW = 11;

  localparam logic [7:0] CmdPageBase  = 8'hB0;
  localparam logic [7:0] CmdColLoBase = 8'h00;
  localparam logic [7:0] CmdColHiBase = 8'h10;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } lpfb_action_e;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_TOGGLE = 2'd2,
    MODE_KEEP   = 2'd3
  } lpfb_mode_e;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_READ = 2'd2
  } lpfb_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } lpfb_state_e;

  // one classified request as it travels from front to back
  typedef struct packed {
    lpfb_action_e          action;
    logic                  in_range;
    logic [AddrMaxW-1:0]   addr;
    logic [3:0]            page;
    logic [6:0]            col;
    logic [2:0]            bit_sel;
    lpfb_mode_e            mode;
  } lpfb_cmd_t;

  function automatic logic [7:0] update_byte(logic [7:0] cur, logic [2:0] bit_sel,
                                             lpfb_mode_e mode);
    logic [7:0] mask;
    logic [7:0] res;
    mask = 8'h01 << bit_sel;
    case (mode)
      MODE_SET:    res = cur | mask;
      MODE_CLEAR:  res = cur & ~mask;
      MODE_TOGGLE: res = cur ^ mask;
      default:     res = cur;
    endcase
    return res;
  endfunction

endpackage

// File: hdl/lpfb_front.sv
// front end: accepts request beats, range checks them and computes the store index
`timescale 1ns / 1ps

module lpfb_front #(
  parameter int unsigned COLUMNS = 96,
  parameter int unsigned PAGES   = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clearing_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [23:0]        s_axis_tdata_i,  // col[7:0], row[15:8], pixel_mode[17:16]
  input  logic               s_axis_tuser_i,  // action
  output logic               push_o,
  output lpfb_pkg::lpfb_cmd_t cmd_o,
  input  logic               full_i
);

  localparam logic [8:0] ColLimit = 9'(COLUMNS);
  localparam logic [8:0] RowLimit = 9'(8 * PAGES);

  logic                valid_q, valid_d;
  lpfb_pkg::lpfb_cmd_t cmd_q, cmd_d;
  logic [7:0]          col, row;
  logic [15:0]         addr_full;
  logic                in_range, keep, accept, stage_free;

  assign col       = s_axis_tdata_i[7:0];
  assign row       = s_axis_tdata_i[15:8];
  assign in_range  = ({1'b0, col} < ColLimit) && ({1'b0, row} < RowLimit);
  assign addr_full = 16'(col) * 16'(PAGES) + 16'(row[7:3]);
  // out-of-range writes produce nothing and are dropped here
  assign keep      = (s_axis_tuser_i == 1'b1) || in_range;

  assign stage_free      = !valid_q || !full_i;
  assign s_axis_tready_o = !clearing_i && stage_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_o          = valid_q && !full_i;
  assign cmd_o           = cmd_q;

  always_comb begin
    cmd_d.action   = lpfb_pkg::lpfb_action_e'(s_axis_tuser_i);
    cmd_d.in_range = in_range;
    cmd_d.addr     = addr_full[lpfb_pkg::AddrMaxW-1:0];
    cmd_d.page     = row[6:3];
    cmd_d.col      = col[6:0];
    cmd_d.bit_sel  = row[2:0];
    cmd_d.mode     = lpfb_pkg::lpfb_mode_e'(s_axis_tdata_i[17:16]);
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_free) begin
      valid_d = accept && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: hdl/lpfb_fifo.sv
// two-entry queue of classified requests between front and back
`timescale 1ns / 1ps

module lpfb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpfb_pkg::lpfb_cmd_t cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output lpfb_pkg::lpfb_cmd_t cmd_o
);

  lpfb_pkg::lpfb_cmd_t entry_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/lpfb_back.sv
// back end: frame store, read-modify-write and output word sequencing
`timescale 1ns / 1ps

module lpfb_back #(
  parameter int unsigned DEPTH = 864
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lpfb_pkg::lpfb_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                clearing_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,  // word[7:0], pixel[8]
  output logic [1:0]          m_axis_tuser_o,  // kind
  output logic                m_axis_tlast_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]            frame_q [DEPTH];
  lpfb_pkg::lpfb_state_e state_q, state_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [1:0]            cnt_q, cnt_d;
  lpfb_pkg::lpfb_cmd_t   cmd_q;
  logic                  rmw_q;
  logic [7:0]            rd_q;
  logic [7:0]            byte_q;
  logic [7:0]            new_byte;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_word_q;
  logic                  out_pixel_q, out_last_q;
  lpfb_pkg::lpfb_kind_e  out_kind_q;

  logic                  slot_free, load, done, clr_last;
  lpfb_pkg::lpfb_kind_e  ld_kind;
  logic [7:0]            ld_word;
  logic                  ld_pixel, ld_last;

  assign slot_free  = !out_valid_q || m_axis_tready_i;
  assign clr_last   = (clr_q == AW'(DEPTH - 1));
  assign cmd_pop_o  = done && cmd_valid_i;
  assign clearing_o = (state_q == lpfb_pkg::ST_CLEAR);
  assign new_byte   = lpfb_pkg::update_byte(rd_q, cmd_q.bit_sel, cmd_q.mode);

  // output side of the sequencer
  always_comb begin
    load     = 1'b0;
    done     = 1'b0;
    ld_kind  = lpfb_pkg::KIND_CMD;
    ld_word  = 8'h00;
    ld_pixel = 1'b0;
    ld_last  = 1'b0;
    case (state_q)
      lpfb_pkg::ST_IDLE: begin
        done = 1'b1;
      end
      lpfb_pkg::ST_WRITE: begin
        load = slot_free;
        case (cnt_q)
          2'd0: ld_word = lpfb_pkg::CmdPageBase | {4'h0, cmd_q.page};
          2'd1: ld_word = lpfb_pkg::CmdColLoBase | {4'h0, cmd_q.col[3:0]};
          2'd2: ld_word = lpfb_pkg::CmdColHiBase | {5'h00, cmd_q.col[6:4]};
          default: begin
            ld_kind = lpfb_pkg::KIND_DATA;
            ld_word = byte_q;
            ld_last = 1'b1;
            done    = slot_free;
          end
        endcase
      end
      lpfb_pkg::ST_READ: begin
        load     = slot_free;
        done     = slot_free;
        ld_kind  = lpfb_pkg::KIND_READ;
        ld_pixel = cmd_q.in_range & rd_q[cmd_q.bit_sel];
        ld_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    case (state_q)
      lpfb_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_last) begin
          state_d = lpfb_pkg::ST_IDLE;
        end
      end
      default: begin
        if (load) begin
          cnt_d = cnt_q + 2'd1;
        end
        if (done) begin
          cnt_d = 2'd0;
          if (cmd_valid_i) begin
            state_d = (cmd_i.action == lpfb_pkg::ACT_READ) ? lpfb_pkg::ST_READ
                                                           : lpfb_pkg::ST_WRITE;
          end else begin
            state_d = lpfb_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpfb_pkg::ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= 2'd0;
      rmw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      rmw_q       <= cmd_pop_o && (cmd_i.action == lpfb_pkg::ACT_WRITE);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (rmw_q) begin
      byte_q <= new_byte;
    end
    if (load) begin
      out_kind_q  <= ld_kind;
      out_word_q  <= ld_word;
      out_pixel_q <= ld_pixel;
      out_last_q  <= ld_last;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == lpfb_pkg::ST_CLEAR) begin
      frame_q[clr_q] <= 8'h00;
    end else if (rmw_q) begin
      frame_q[cmd_q.addr[AW-1:0]] <= new_byte;
    end
    if (cmd_pop_o) begin
      rd_q <= frame_q[cmd_i.addr[AW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'h00, out_pixel_q, out_word_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: hdl/lcd_pixel_framebuffer_engine_core.sv
// Page-organized monochrome LCD frame buffer with pixel write and read requests.
//
// Input stream (s_axis): one beat is one request. tuser is the action, 0 writes
// a pixel by pixel_mode (set, clear, toggle, keep), 1 reads a pixel. tdata
// carries col, row and pixel_mode.
// Output stream (m_axis): a write inside the panel gives four beats, page select,
// column low and column high commands (tuser 0) and then the updated byte
// (tuser 1, tlast). A read gives one beat (tuser 2, tlast) with the pixel in
// tdata[8], 0 when outside the panel. Writes outside the panel give nothing.
// Timing: a write occupies the output sequencer for its four beats, which set the
// write rate, and a read for one beat; the registered store read overlaps the last
// beat of the request before. From acceptance a request passes the front register,
// the queue and the sequencer's command register before its first beat is output.
// A two-entry queue sits between the front end and the sequencer, so requests
// keep being accepted while the output is stalled, until the queue is full.
// Reset: the store is cleared by a sweep over all COLUMNS*PAGES entries (864 by
// default); tready stays low during that sweep.
`timescale 1ns / 1ps

module lcd_pixel_framebuffer_engine_core #(
  parameter int unsigned COLUMNS = 96,
  parameter int unsigned PAGES   = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // col[7:0], row[15:8], pixel_mode[17:16]
  input  logic        s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // word[7:0], pixel[8]
  output logic [1:0]  m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o
);

  logic                clearing;
  logic                push, full, q_valid, pop;
  lpfb_pkg::lpfb_cmd_t push_cmd, head_cmd;

  lpfb_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clearing_i      (clearing),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  lpfb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  lpfb_back #(
    .DEPTH (COLUMNS * PAGES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // nothing leaves or enters while the store is being cleared
  a_quiet_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!m_axis_tvalid_o && !s_axis_tready_o))
    else $error("activity during store clear");

  // only data and read answers close a request
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o != lpfb_pkg::KIND_CMD)))
    else $error("tlast does not match kind");

  // the queue is never popped empty
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // a read answer carries no word
  a_read_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == lpfb_pkg::KIND_READ))
      |-> (m_axis_tdata_o[7:0] == 8'h00))
    else $error("read answer with nonzero word");
`endif

endmodule
